/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the separator string splitter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define SSPLIT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high
`define SSPLIT_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ssplit_pkg.sv */
// ----------------------------------------------------------------------------
// ssplit_pkg
// Types and constants shared by the separator string splitter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ssplit_pkg;

  // Largest separator the window can hold
  localparam int SEP_MAX     = 8;
  localparam int WIN_IDX_W   = ($clog2(SEP_MAX) > 0) ? $clog2(SEP_MAX) : 1;
  localparam int CNT_W       = $clog2(SEP_MAX + 1);

  // Register and port widths
  localparam int SEP_LEN_W   = 4;
  localparam int SEP_BYTES_W = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int BYTE_W      = 8;
  localparam int OUT_USER_W  = 2;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEP_LEN   = 1'b0,
    REG_SEP_BYTES = 1'b1
  } cfg_reg_t;

  // Result kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SEG_END = 1'b1;

  // Effective separator setup seen by the engine
  typedef struct packed {
    logic [CNT_W-1:0]               sep_len;
    logic [SEP_MAX-1:0][BYTE_W-1:0] sep_bytes;
  } sep_cfg_t;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              kind;
    logic              final_segment;
    logic              last_of_run;
  } result_t;

endpackage

`default_nettype wire

/* design/ssplit_cfg.sv */
// ----------------------------------------------------------------------------
// ssplit_cfg
// Separator registers and the clamped separator length.
// ----------------------------------------------------------------------------
`default_nettype none

module ssplit_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire ssplit_pkg::cfg_reg_t          cfg_index,
  input  wire logic [ssplit_pkg::CFG_DATA_W-1:0] cfg_data,
  output ssplit_pkg::sep_cfg_t               cfg
);
  import ssplit_pkg::*;

  logic [SEP_LEN_W-1:0]   sep_len;
  logic [SEP_BYTES_W-1:0] sep_bytes;

  // Decode register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_len   <= SEP_LEN_W'(1);
      sep_bytes <= SEP_BYTES_W'(44);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
        REG_SEP_BYTES: sep_bytes <= cfg_data[SEP_BYTES_W-1:0];
      endcase
    end
  end

  // Clamp length to 1..SEP_MAX
  always_comb begin
    if (sep_len == '0) begin
      cfg.sep_len = CNT_W'(1);
    end else if (sep_len > SEP_LEN_W'(SEP_MAX)) begin
      cfg.sep_len = CNT_W'(SEP_MAX);
    end else begin
      cfg.sep_len = CNT_W'(sep_len);
    end
    cfg.sep_bytes = sep_bytes[SEP_MAX*BYTE_W-1:0];
  end

endmodule

`default_nettype wire

/* design/ssplit_engine.sv */
// ----------------------------------------------------------------------------
// ssplit_engine
// Input register, separator window and the per-cycle split step.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssplit_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ssplit_pkg::sep_cfg_t          cfg,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [ssplit_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
  input  wire logic                          s_axis_tuser,   // [0] byte_present
  input  wire logic                          s_axis_tlast,   // source_end
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output ssplit_pkg::result_t                res
);
  import ssplit_pkg::*;

  // Held request
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_present;
  logic              in_end;
  logic              byte_done;

  // Split state
  logic [BYTE_W-1:0] window [SEP_MAX];
  logic [BYTE_W-1:0] window_next [SEP_MAX];
  logic [BYTE_W-1:0] win_app [SEP_MAX];
  logic [CNT_W-1:0]  count, count_next;
  logic              started, started_next;
  logic              byte_done_next;

  logic [SEP_MAX-1:0] sep_hit;
  logic               match;
  logic               full;
  logic               pres_pending;
  logic               has_res;
  logic               item_done;
  logic               step_fire;
  logic               in_accept;

  // Window with the held byte placed at the fill position, and separator compare
  always_comb begin
    for (int i = 0; i < SEP_MAX; i++) begin
      win_app[i] = (WIN_IDX_W'(i) == count[WIN_IDX_W-1:0]) ? in_byte : window[i];
      sep_hit[i] = (CNT_W'(i) >= cfg.sep_len) || (win_app[i] == cfg.sep_bytes[i]);
    end
    match = &sep_hit;
    full  = (CNT_W'(count + CNT_W'(1)) == cfg.sep_len);
  end

  // One step: at most one result per cycle
  always_comb begin
    pres_pending   = in_present && !byte_done;
    has_res        = 1'b0;
    item_done      = 1'b0;
    res            = '0;
    window_next    = window;
    count_next     = count;
    started_next   = started;
    byte_done_next = byte_done;

    if (pres_pending && (count >= cfg.sep_len)) begin
      // Drain bytes left over from a longer separator
      has_res      = 1'b1;
      res.out_byte = window[0];
      res.kind     = KIND_DATA;
      for (int i = 0; i < SEP_MAX - 1; i++) window_next[i] = window[i + 1];
      count_next   = count - CNT_W'(1);
    end else if (pres_pending) begin
      // Take the byte in
      started_next   = 1'b1;
      byte_done_next = 1'b1;
      item_done      = !in_end;
      if (full && match) begin
        has_res         = 1'b1;
        res.kind        = KIND_SEG_END;
        res.last_of_run = !in_end;
        count_next      = '0;
      end else if (full) begin
        has_res         = 1'b1;
        res.out_byte    = win_app[0];
        res.kind        = KIND_DATA;
        res.last_of_run = !in_end;
        for (int i = 0; i < SEP_MAX - 1; i++) window_next[i] = win_app[i + 1];
      end else begin
        window_next = win_app;
        count_next  = count + CNT_W'(1);
      end
    end else if (in_end && started) begin
      // Flush pending bytes, then close the source
      has_res = 1'b1;
      if (count != '0) begin
        res.out_byte = window[0];
        res.kind     = KIND_DATA;
        for (int i = 0; i < SEP_MAX - 1; i++) window_next[i] = window[i + 1];
        count_next   = count - CNT_W'(1);
      end else begin
        res.kind          = KIND_SEG_END;
        res.final_segment = 1'b1;
        res.last_of_run   = 1'b1;
        started_next      = 1'b0;
        item_done         = 1'b1;
      end
    end else begin
      item_done = 1'b1;
    end
  end

  // Handshakes
  assign res_valid     = in_valid && has_res;
  assign step_fire     = in_valid && (!has_res || res_ready);
  assign s_axis_tready = !in_valid || (step_fire && item_done);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // Hold the request and advance the control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      byte_done <= 1'b0;
      count     <= '0;
      started   <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid  <= 1'b1;
        byte_done <= 1'b0;
      end else if (step_fire) begin
        in_valid  <= !item_done;
        byte_done <= byte_done_next;
      end
      if (step_fire) begin
        count   <= count_next;
        started <= started_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte    <= s_axis_tdata;
      in_present <= s_axis_tuser;
      in_end     <= s_axis_tlast;
    end
    if (step_fire) begin
      window <= window_next;
    end
  end

  `SSPLIT_ASSERT_IMP(a_final_empty, clk, rst, res_valid && res.final_segment, count == '0, "final segment end issued with bytes pending")
  `SSPLIT_ASSERT_NEXT(a_final_clears, clk, rst, step_fire && res.final_segment, !started && count == '0, "source state not cleared after final segment end")
  `SSPLIT_ASSERT_IMP(a_match_end, clk, rst, res_valid && res.kind && !res.final_segment, pres_pending && full && match, "segment end without a separator match")

endmodule

`default_nettype wire

/* design/ssplit_out_reg.sv */
// ----------------------------------------------------------------------------
// ssplit_out_reg
// Output register that holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ssplit_out_reg (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              res_valid,
  output logic                                   res_ready,
  input  wire ssplit_pkg::result_t               res,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ssplit_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] out_byte
  output logic [ssplit_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // [0] kind, [1] final_segment
  output logic                                   m_axis_tlast   // last_of_run
);
  import ssplit_pkg::*;

  result_t held;

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  // Load a new result when the slot frees up
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

  assign m_axis_tdata = held.out_byte;
  assign m_axis_tuser = {held.final_segment, held.kind};
  assign m_axis_tlast = held.last_of_run;

endmodule

`default_nettype wire

/* design/separator_string_splitter_core.sv */
// ----------------------------------------------------------------------------
// separator_string_splitter_core
// Splits a byte stream at a configured separator of 1 to 8 bytes.
// ----------------------------------------------------------------------------
// Each request carries at most one source byte (tuser) and may close the
// source (tlast). While the output is not stalled, the core emits one
// result per cycle through a single output register: segment bytes
// (tuser[0] = 0), delayed by up to separator length - 1 bytes, and
// segment-end marks (tuser[0] = 1, with tuser[1] set on the mark that
// closes the source); tlast flags the last result of each request. The
// byte of a request yields at most one result, and a request that yields
// several results is held until each has gone out. Closing a source first
// emits the pending bytes and then the final segment-end mark, after the
// byte itself is taken in when the closing request also carries one.
// After the separator length is lowered mid-source, the next byte first
// drains the surplus pending bytes as segment bytes. Separator registers
// may be written only while the core is idle; the window has no clearing
// pass and accepts a request in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module separator_string_splitter_core (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire ssplit_pkg::cfg_reg_t              cfg_index,
  input  wire logic [ssplit_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ssplit_pkg::BYTE_W-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  wire logic                              s_axis_tuser,  // [0] byte_present
  input  wire logic                              s_axis_tlast,  // source_end
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [ssplit_pkg::BYTE_W-1:0]          m_axis_tdata,  // [7:0] out_byte
  output logic [ssplit_pkg::OUT_USER_W-1:0]      m_axis_tuser,  // [0] kind, [1] final_segment
  output logic                                   m_axis_tlast   // last_of_run
);
  import ssplit_pkg::*;

  sep_cfg_t cfg;
  result_t  res;
  logic     res_valid;
  logic     res_ready;

  ssplit_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ssplit_engine u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res)
  );

  ssplit_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
